[rtl/core/cwr_pkg.sv]
// Package for the text console cell writer: field widths, codes, character
// constants, configuration layout and the colour remap table.
// No dependencies.
`default_nettype none

package cwr_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CHAR_W     = 8;
	localparam int ADDR_W     = 11;
	localparam int VALUE_W    = 16;
	localparam int STATUS_W   = 2;
	localparam int COLOR_W    = 3;
	localparam int ATTR_W     = 8;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOLD_ON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_ON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONCEAL_ON = 3'd4;

	localparam logic [COLOR_W-1:0] FORE_RESET = 3'd7;
	localparam logic [COLOR_W-1:0] BACK_RESET = 3'd0;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_END    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ESCAPE = 2'd3;

	// interpreted characters
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// continuation marker progress: which marker cell comes next
	typedef enum logic [1:0] {
		PH_NONE,
		PH_CONT1,
		PH_CONT2,
		PH_CONT3
	} phase_t;

	typedef struct packed {
		logic [COLOR_W-1:0] fore_color;
		logic [COLOR_W-1:0] back_color;
		logic               bold_on;
		logic               inverse_on;
		logic               conceal_on;
	} cfg_t;

	typedef struct packed {
		logic                write_valid;
		logic [ADDR_W-1:0]   cell_addr;
		logic [VALUE_W-1:0]  cell_value;
		logic [STATUS_W-1:0] status;
		logic                last;
	} res_t;

	// ANSI colour number to display order
	function automatic logic [COLOR_W-1:0] color_map(input logic [COLOR_W-1:0] c);
		logic [COLOR_W-1:0] m;
		unique case (c)
			3'd0: m = 3'd0;
			3'd1: m = 3'd4;
			3'd2: m = 3'd2;
			3'd3: m = 3'd6;
			3'd4: m = 3'd1;
			3'd5: m = 3'd5;
			3'd6: m = 3'd3;
			default: m = 3'd7;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[rtl/core/cwr_attr.sv]
// Attribute byte builder: colour remap, bold, inverse and conceal.
// Depends on cwr_pkg.
`default_nettype none

module cwr_attr (
	input  var cwr_pkg::cfg_t              cfg,
	output logic [cwr_pkg::ATTR_W-1:0]     attr
);

	logic [3:0] fore_base;
	logic [3:0] back_base;
	logic [3:0] fore_inv;
	logic [3:0] back_inv;
	logic [3:0] fore_fin;

	assign fore_base = {cfg.bold_on, cwr_pkg::color_map(cfg.fore_color)};
	assign back_base = {1'b0, cwr_pkg::color_map(cfg.back_color)};

	assign fore_inv = cfg.inverse_on ? back_base : fore_base;
	assign back_inv = cfg.inverse_on ? fore_base : back_base;
	assign fore_fin = cfg.conceal_on ? back_inv : fore_inv;

	assign attr = {back_inv, fore_fin};

endmodule

`default_nettype wire

[rtl/core/cwr_step.sv]
// Per-result step logic: decodes one character against the cursor and
// gives one result plus the next cursor and marker progress.
// Depends on cwr_pkg.
`default_nettype none

module cwr_step #(
	parameter  int COLUMNS = cwr_pkg::COLUMNS_DEF,
	parameter  int ROWS    = cwr_pkg::ROWS_DEF,
	localparam int COL_W   = $clog2(COLUMNS + 1),
	localparam int ROW_W   = $clog2(ROWS + 2)
) (
	input  logic                          raw,
	input  logic [cwr_pkg::CHAR_W-1:0]    ch,
	input  logic                          more,
	input  cwr_pkg::phase_t               phase,
	input  logic [COL_W-1:0]              col,
	input  logic [ROW_W-1:0]              row,
	input  logic [cwr_pkg::ATTR_W-1:0]    attr,
	output cwr_pkg::res_t                 res,
	output logic [COL_W-1:0]              col_n,
	output logic [ROW_W-1:0]              row_n,
	output cwr_pkg::phase_t               phase_n
);

	localparam int PW = ROW_W + COL_W;
	localparam int SW = (PW > cwr_pkg::ADDR_W) ? PW : cwr_pkg::ADDR_W;
	localparam logic [COL_W:0]   COLS_V = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W-1:0] ROWS_V = ROW_W'(ROWS);
	localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);

	logic                         full;
	logic [ROW_W-1:0]             adv_row;
	logic                         cur_wrap;
	logic [COL_W:0]               tab_col;

	// cell emission
	logic                         emit;
	logic [ROW_W-1:0]             erow;
	logic [COL_W-1:0]             ecol;
	logic [cwr_pkg::CHAR_W-1:0]   echar;
	logic [COL_W:0]               einc;
	logic                         ewrap;
	logic [ROW_W-1:0]             erow_adv;
	logic [SW-1:0]                prod;
	logic [SW-1:0]                addr_full;

	// non-emitting outcome
	logic [COL_W-1:0]             col_x;
	logic [ROW_W-1:0]             row_x;
	logic [cwr_pkg::STATUS_W-1:0] status;
	logic                         last;

	assign full     = row > ROWS_V;
	assign adv_row  = (row <= ROWS_V) ? row + 1'b1 : row;
	assign cur_wrap = ({1'b0, col} + 1'b1) > COLS_V;
	// next tab stop of the zero-based column, back to one-based
	assign tab_col  = {1'b0, (col - 1'b1) & ~COL_W'(3)} + (COL_W + 1)'(5);

	always_comb begin
		emit    = 1'b0;
		erow    = row;
		ecol    = col;
		echar   = ch;
		col_x   = col;
		row_x   = row;
		status  = cwr_pkg::ST_OK;
		last    = 1'b1;
		phase_n = cwr_pkg::PH_NONE;
		unique case (phase)
			cwr_pkg::PH_CONT1: begin
				emit    = 1'b1;
				echar   = cwr_pkg::CH_GT;
				last    = 1'b0;
				phase_n = cwr_pkg::PH_CONT2;
			end
			cwr_pkg::PH_CONT2: begin
				emit    = 1'b1;
				echar   = cwr_pkg::CH_GT;
				last    = 1'b0;
				phase_n = cwr_pkg::PH_CONT3;
			end
			cwr_pkg::PH_CONT3: begin
				emit  = 1'b1;
				echar = cwr_pkg::CH_SPACE;
			end
			default: begin
				if (raw) begin
					if (full)
						status = cwr_pkg::ST_FULL;
					else
						emit = 1'b1;
				end else begin
					unique case (ch)
						cwr_pkg::CH_NUL: ;
						cwr_pkg::CH_LF: begin
							if (full) begin
								status = cwr_pkg::ST_FULL;
							end else begin
								row_x  = adv_row;
								col_x  = COL_ONE;
								status = (adv_row > ROWS_V) ? cwr_pkg::ST_END : cwr_pkg::ST_OK;
							end
						end
						cwr_pkg::CH_TAB: begin
							if (tab_col > COLS_V) begin
								row_x = adv_row;
								col_x = COL_ONE;
								if (adv_row > ROWS_V) begin
									status = cwr_pkg::ST_END;
								end else if (more) begin
									// first marker cell goes out with the tab itself
									emit    = 1'b1;
									erow    = adv_row;
									ecol    = COL_ONE;
									echar   = cwr_pkg::CH_GT;
									last    = 1'b0;
									phase_n = cwr_pkg::PH_CONT2;
								end
							end else begin
								col_x = tab_col[COL_W-1:0];
							end
						end
						cwr_pkg::CH_FF:  status = cwr_pkg::ST_END;
						cwr_pkg::CH_ESC: status = cwr_pkg::ST_ESCAPE;
						default: begin
							if (full) begin
								status = cwr_pkg::ST_FULL;
							end else begin
								emit = 1'b1;
								if (cur_wrap && more && adv_row <= ROWS_V) begin
									last    = 1'b0;
									phase_n = cwr_pkg::PH_CONT1;
								end
							end
						end
					endcase
				end
			end
		endcase
	end

	assign einc     = {1'b0, ecol} + 1'b1;
	assign ewrap    = einc > COLS_V;
	assign erow_adv = (erow <= ROWS_V) ? erow + 1'b1 : erow;

	assign prod      = SW'(erow - 1'b1) * SW'(COLUMNS);
	assign addr_full = prod + SW'(ecol - 1'b1);

	assign col_n = emit ? (ewrap ? COL_ONE : einc[COL_W-1:0]) : col_x;
	assign row_n = emit ? (ewrap ? erow_adv : erow) : row_x;

	always_comb begin
		res.write_valid = emit;
		res.cell_addr   = emit ? addr_full[cwr_pkg::ADDR_W-1:0] : '0;
		res.cell_value  = emit ? {attr, echar} : '0;
		res.status      = status;
		res.last        = last;
	end

endmodule

`default_nettype wire

[rtl/core/text_console_cell_writer.sv]
// Text console cell writer, top level. A character accepted from the input
// stream is held in the input register, and each of its results is registered
// in the output register, which is loaded only while it is empty or being taken.
// Throughput: one character per cycle while the output is not held by
// back-pressure; a printable that wraps and adds the ">> " marker holds the input
// register for four results, a wrapping tab that adds it for three results.
// Reset: cursor to row 1 column 1, colour registers to their defaults,
// input and output registers empty. Depends on cwr_pkg, cwr_attr, cwr_step.
`default_nettype none

module text_console_cell_writer #(
	parameter int COLUMNS = cwr_pkg::COLUMNS_DEF,
	parameter int ROWS    = cwr_pkg::ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cwr_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] char_code, [8] more_follows
	input  logic                              s_tuser,  // [0] req_type
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cwr_pkg::M_TDATA_W-1:0]     m_tdata,  // [10:0] cell_addr, [26:11] cell_value
	output logic [cwr_pkg::M_TUSER_W-1:0]     m_tuser,  // [0] write_valid, [2:1] status
	output logic                              m_tlast,
	// configuration
	input  logic                              cfg_we,
	input  logic [cwr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cwr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int COL_W = $clog2(COLUMNS + 1);
	localparam int ROW_W = $clog2(ROWS + 2);
	localparam int PAD_W = cwr_pkg::M_TDATA_W - cwr_pkg::ADDR_W - cwr_pkg::VALUE_W;

	cwr_pkg::cfg_t                cfg_q;
	logic [cwr_pkg::ATTR_W-1:0]   attr;

	logic                         valid_s1;
	logic                         raw_s1;
	logic [cwr_pkg::CHAR_W-1:0]   ch_s1;
	logic                         more_s1;

	logic [COL_W-1:0]             col_q;
	logic [ROW_W-1:0]             row_q;
	cwr_pkg::phase_t              phase_q;

	cwr_pkg::res_t                res;
	logic [COL_W-1:0]             col_n;
	logic [ROW_W-1:0]             row_n;
	cwr_pkg::phase_t              phase_n;

	logic                         out_valid_q;
	cwr_pkg::res_t                out_res_q;

	logic                         proc;
	logic                         in_fire;

	assign proc     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || (proc && res.last);
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fore_color <= cwr_pkg::FORE_RESET;
			cfg_q.back_color <= cwr_pkg::BACK_RESET;
			cfg_q.bold_on    <= 1'b0;
			cfg_q.inverse_on <= 1'b0;
			cfg_q.conceal_on <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cwr_pkg::REG_FORE_COLOR: cfg_q.fore_color <= cfg_data;
				cwr_pkg::REG_BACK_COLOR: cfg_q.back_color <= cfg_data;
				cwr_pkg::REG_BOLD_ON:    cfg_q.bold_on    <= cfg_data[0];
				cwr_pkg::REG_INVERSE_ON: cfg_q.inverse_on <= cfg_data[0];
				cwr_pkg::REG_CONCEAL_ON: cfg_q.conceal_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cwr_attr u_attr (
		.cfg  (cfg_q),
		.attr (attr)
	);

	// input register: held until the last result of its character enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_fire)
			valid_s1 <= 1'b1;
		else if (proc && res.last)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_s1  <= s_tuser;
			ch_s1   <= s_tdata[cwr_pkg::CHAR_W-1:0];
			more_s1 <= s_tdata[cwr_pkg::CHAR_W];
		end
	end

	cwr_step #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_step (
		.raw     (raw_s1),
		.ch      (ch_s1),
		.more    (more_s1),
		.phase   (phase_q),
		.col     (col_q),
		.row     (row_q),
		.attr    (attr),
		.res     (res),
		.col_n   (col_n),
		.row_n   (row_n),
		.phase_n (phase_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= COL_W'(1);
			row_q   <= ROW_W'(1);
			phase_q <= cwr_pkg::PH_NONE;
		end else if (proc) begin
			col_q   <= col_n;
			row_q   <= row_n;
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (proc)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (proc)
			out_res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_res_q.cell_value, out_res_q.cell_addr};
	assign m_tuser  = {out_res_q.status, out_res_q.write_valid};
	assign m_tlast  = out_res_q.last;

	a_write_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.write_valid |-> out_res_q.status == cwr_pkg::ST_OK)
		else $error("cell write carries a non-zero status");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q != '0 && col_q <= COLUMNS)
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != '0 && row_q <= ROWS + 1)
		else $error("cursor row out of range");

	a_marker_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != cwr_pkg::PH_NONE |-> valid_s1)
		else $error("continuation marker pending without a held character");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cell_writer: drives characters on the input
// stream, predicts the cell writes and checks every result. Depends on cwr_pkg and the RTL.

module testbench;
	import cwr_pkg::*;

	localparam int COLS     = COLUMNS_DEF;
	localparam int PAGE_ROWS = ROWS_DEF;

	localparam logic REQ_TEXT = 1'b0;
	localparam logic REQ_RAW  = 1'b1;

	typedef enum logic [1:0] {RX_OPEN, RX_PERIODIC, RX_RANDOM} rx_mode_t;
	typedef enum logic [1:0] {END_NEWLINE, END_TAB, END_PRINTABLE} page_end_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	text_console_cell_writer #(
		.COLUMNS(COLS),
		.ROWS(PAGE_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predicted console state
	int               cur_col;
	int               cur_row;
	logic [COLOR_W-1:0] fore_q;
	logic [COLOR_W-1:0] back_q;
	logic             bold_q;
	logic             inverse_q;
	logic             conceal_q;

	res_t             pending_cells[$];
	res_t             step_res[4];
	int               step_n;

	int               burst_left;
	int               errors;
	int               chars_sent;
	int               results_seen;
	int               writes_seen;
	int               markers_seen;
	int               reg_writes;
	int               rx_tick;
	rx_mode_t         rx_mode;
	string            ending_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [3:0] display_order(input logic [COLOR_W-1:0] c);
		case (c)
			3'd0: return 4'd0;
			3'd1: return 4'd4;
			3'd2: return 4'd2;
			3'd3: return 4'd6;
			3'd4: return 4'd1;
			3'd5: return 4'd5;
			3'd6: return 4'd3;
			default: return 4'd7;
		endcase
	endfunction

	function automatic logic [ATTR_W-1:0] attr_now();
		logic [3:0] fore;
		logic [3:0] back;
		logic [3:0] t;
		back = display_order(back_q);
		fore = display_order(fore_q);
		if (bold_q) fore = fore + 4'd8;
		if (inverse_q) begin
			t = fore;
			fore = back;
			back = t;
		end
		if (conceal_q) fore = back;
		return {back, fore};
	endfunction

	function automatic void next_row();
		if (cur_row <= PAGE_ROWS) cur_row++;
		cur_col = 1;
	endfunction

	function automatic void no_write(input logic [STATUS_W-1:0] st);
		res_t r;
		r = '0;
		r.status = st;
		step_res[step_n] = r;
		step_n++;
	endfunction

	// writes at the cursor and advances it; returns 1 on a line wrap
	function automatic bit place_cell(input logic [CHAR_W-1:0] ch);
		res_t r;
		int a;
		a = (cur_row - 1) * COLS + (cur_col - 1);
		r.write_valid = 1'b1;
		r.cell_addr = a[ADDR_W-1:0];
		r.cell_value = {attr_now(), ch};
		r.status = ST_OK;
		r.last = 1'b0;
		step_res[step_n] = r;
		step_n++;
		cur_col++;
		if (cur_col > COLS) begin
			next_row();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void add_marker();
		void'(place_cell(CH_GT));
		void'(place_cell(CH_GT));
		void'(place_cell(CH_SPACE));
		markers_seen++;
	endfunction

	function automatic void predict_cells(input logic raw, input logic [CHAR_W-1:0] ch,
			input logic more);
		bit wrapped;
		step_n = 0;
		if (raw) begin
			if (cur_row > PAGE_ROWS) no_write(ST_FULL);
			else void'(place_cell(ch));
		end else begin
			case (ch)
				CH_NUL: no_write(ST_OK);
				CH_LF: begin
					if (cur_row > PAGE_ROWS) begin
						no_write(ST_FULL);
					end else begin
						next_row();
						no_write(cur_row > PAGE_ROWS ? ST_END : ST_OK);
					end
				end
				CH_TAB: begin
					cur_col = (((cur_col - 1) & ~3) + 4) + 1;
					if (cur_col > COLS) begin
						next_row();
						if (cur_row > PAGE_ROWS) no_write(ST_END);
						else if (more) add_marker();
						else no_write(ST_OK);
					end else begin
						no_write(ST_OK);
					end
				end
				CH_FF: no_write(ST_END);
				CH_ESC: no_write(ST_ESCAPE);
				default: begin
					if (cur_row > PAGE_ROWS) begin
						no_write(ST_FULL);
					end else begin
						wrapped = place_cell(ch);
						if (wrapped && more && cur_row <= PAGE_ROWS) add_marker();
					end
				end
			endcase
		end
		step_res[step_n-1].last = 1'b1;
		for (int k = 0; k < step_n; k++) pending_cells.push_back(step_res[k]);
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_char(input logic raw, input logic [CHAR_W-1:0] ch, input logic more);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W-CHAR_W-1){1'b0}}, more, ch};
		s_tuser <= raw;
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		predict_cells(raw, ch, more);
		chars_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// hold the sender until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_cells.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FORE_COLOR: fore_q = val;
			REG_BACK_COLOR: back_q = val;
			REG_BOLD_ON:    bold_q = val[0];
			REG_INVERSE_ON: inverse_q = val[0];
			REG_CONCEAL_ON: conceal_q = val[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_attrs(input logic [2:0] fg, input logic [2:0] bg, input logic bold,
			input logic inv, input logic conc);
		drain_results();
		set_reg(REG_FORE_COLOR, fg);
		set_reg(REG_BACK_COLOR, bg);
		// upper data bits must be ignored by the flag registers
		set_reg(REG_BOLD_ON, {2'($urandom_range(3)), bold});
		set_reg(REG_INVERSE_ON, {2'($urandom_range(3)), inv});
		set_reg(REG_CONCEAL_ON, {2'($urandom_range(3)), conc});
	endtask

	function automatic bit is_control(input logic [CHAR_W-1:0] ch);
		return ch == CH_NUL || ch == CH_TAB || ch == CH_LF || ch == CH_FF || ch == CH_ESC;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_printable();
		logic [CHAR_W-1:0] ch;
		ch = CHAR_W'($urandom_range(255));
		while (is_control(ch)) ch = CHAR_W'($urandom_range(255));
		return ch;
	endfunction

	task automatic report_mismatch(input string what, input res_t want, input res_t got);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s", $time, what);
			$display("  expected wv=%0b addr=%0d value=%h status=%0d last=%0b",
				want.write_valid, want.cell_addr, want.cell_value, want.status, want.last);
			$display("  actual   wv=%0b addr=%0d value=%h status=%0d last=%0b",
				got.write_valid, got.cell_addr, got.cell_value, got.status, got.last);
		end
	endtask

	always @(posedge clk) begin : check_result
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.write_valid = m_tuser[0];
			got.cell_addr = m_tdata[ADDR_W-1:0];
			got.cell_value = m_tdata[ADDR_W+VALUE_W-1:ADDR_W];
			got.status = m_tuser[STATUS_W:1];
			got.last = m_tlast;
			results_seen++;
			if (got.write_valid === 1'b1) writes_seen++;
			if (pending_cells.size() == 0) begin
				report_mismatch("result transaction with nothing expected", '0, got);
			end else begin
				want = pending_cells.pop_front();
				if (got.write_valid !== want.write_valid || got.cell_addr !== want.cell_addr ||
						got.cell_value !== want.cell_value || got.status !== want.status ||
						got.last !== want.last)
					report_mismatch("result transaction mismatch", want, got);
			end
		end
	end

	// receiver back-pressure in open, periodic or random mode
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 50 == 0) rx_mode = rx_mode_t'($urandom_range(2));
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_PERIODIC: m_tready <= (rx_tick % 7 != 2) && (rx_tick % 7 != 3);
			default:     m_tready <= ($urandom_range(99) < 65);
		endcase
	end

	task automatic test_attributes();
		// characters at the reset colours first
		send_char(REQ_RAW, 8'h41, 1'b0);
		send_char(REQ_RAW, 8'h00, 1'b1);
		set_attrs(3'd0, 3'd7, 1'b1, 1'b0, 1'b0);
		send_char(REQ_RAW, 8'hFF, 1'b0);
		send_char(REQ_RAW, CH_LF, 1'b1);
		set_attrs(3'd7, 3'd0, 1'b1, 1'b1, 1'b0);
		send_char(REQ_RAW, CH_ESC, 1'b0);
		send_char(REQ_RAW, CH_TAB, 1'b0);
		set_attrs(3'd3, 3'd5, 1'b1, 1'b1, 1'b1);
		send_char(REQ_RAW, 8'h5A, 1'b0);
		set_attrs(3'd7, 3'd7, 1'b0, 1'b0, 1'b1);
		send_char(REQ_RAW, 8'h80, 1'b1);
		// unused indexes must leave the colours alone
		drain_results();
		set_reg(3'd5, 3'd7);
		set_reg(3'd6, 3'd0);
		set_reg(3'd7, 3'd5);
		send_char(REQ_RAW, 8'h7F, 1'b0);
		set_attrs(3'd1, 3'd4, 1'b0, 1'b1, 1'b0);
		send_char(REQ_RAW, 8'h2A, 1'b0);
	endtask

	task automatic test_controls();
		set_attrs(FORE_RESET, BACK_RESET, 1'b0, 1'b0, 1'b0);
		send_char(REQ_TEXT, 8'h48, 1'b1);
		send_char(REQ_TEXT, 8'hFF, 1'b1);
		send_char(REQ_TEXT, 8'h01, 1'b1);
		send_char(REQ_TEXT, CH_NUL, 1'b0);
		send_char(REQ_TEXT, CH_FF, 1'b0);
		send_char(REQ_TEXT, CH_ESC, 1'b1);
		send_char(REQ_TEXT, CH_TAB, 1'b1);
		send_char(REQ_TEXT, CH_TAB, 1'b0);
		send_char(REQ_TEXT, 8'h7E, 1'b0);
		send_char(REQ_TEXT, CH_LF, 1'b0);
		send_char(REQ_TEXT, CH_TAB, 1'b1);
		send_char(REQ_TEXT, CH_LF, 1'b1);
	endtask

	task automatic test_random_text();
		int start;
		int pick;
		int len;
		bit use_tab;
		bit wraps;
		logic more;
		logic [CHAR_W-1:0] ch;
		start = chars_sent;
		while (chars_sent - start < 150 && cur_row < PAGE_ROWS - 3) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				set_attrs(3'($urandom_range(7)), 3'($urandom_range(7)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (pick < 34) begin
				// a string that runs past the end of the line
				wraps = 1'b0;
				while (!wraps) begin
					use_tab = (cur_col <= COLS - 4) ? ($urandom_range(3) != 0) :
						1'($urandom_range(1));
					if (use_tab) wraps = ((((cur_col - 1) & ~3) + 5) > COLS);
					else wraps = (cur_col == COLS);
					more = wraps ? logic'($urandom_range(1)) : 1'b1;
					send_char(REQ_TEXT, use_tab ? CH_TAB : rand_printable(), more);
				end
				if (more) send_char(REQ_TEXT, rand_printable(), 1'b0);
			end else if (pick < 74) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					ch = ($urandom_range(4) == 0) ? CH_TAB : rand_printable();
					send_char(REQ_TEXT, ch, i != len - 1);
				end
				if ($urandom_range(1)) send_char(REQ_TEXT, CH_NUL, 1'b0);
			end else if (pick < 84) begin
				send_char(REQ_RAW, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
			end else if (pick < 92) begin
				case ($urandom_range(2))
					0: ch = CH_LF;
					1: ch = CH_FF;
					default: ch = CH_ESC;
				endcase
				send_char(REQ_TEXT, ch, 1'($urandom_range(1)));
			end else if (pick < 95) begin
				drain_results();
			end else begin
				send_char(1'($urandom_range(1)), CHAR_W'($urandom_range(255)),
					1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_page_end();
		page_end_t kind;
		set_attrs(3'($urandom_range(7)), 3'($urandom_range(7)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
		while (cur_row < PAGE_ROWS) send_char(REQ_TEXT, CH_LF, 1'($urandom_range(1)));
		kind = page_end_t'($urandom_range(2));
		case (kind)
			END_NEWLINE: begin
				ending_seen = "newline";
				send_char(REQ_TEXT, CH_LF, 1'b1);
			end
			END_TAB: begin
				ending_seen = "tab";
				while (cur_row <= PAGE_ROWS) send_char(REQ_TEXT, CH_TAB, 1'b1);
			end
			default: begin
				// wrap onto the row below the page: no marker may follow
				ending_seen = "printable wrap";
				while (cur_col <= COLS - 4) send_char(REQ_TEXT, CH_TAB, 1'b1);
				while (cur_row <= PAGE_ROWS) send_char(REQ_TEXT, rand_printable(), 1'b1);
			end
		endcase
		// everything on a full page
		send_char(REQ_RAW, CHAR_W'($urandom_range(255)), 1'b0);
		send_char(REQ_TEXT, rand_printable(), 1'b1);
		send_char(REQ_TEXT, CH_LF, 1'b0);
		send_char(REQ_TEXT, CH_FF, 1'b0);
		send_char(REQ_TEXT, CH_ESC, 1'b0);
		send_char(REQ_TEXT, CH_NUL, 1'b0);
		for (int i = 0; i < 22; i++) send_char(REQ_TEXT, CH_TAB, 1'b1);
		set_attrs(3'd2, 3'd6, 1'b0, 1'b0, 1'b0);
		send_char(REQ_RAW, 8'h55, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_col = 1;
		cur_row = 1;
		fore_q = FORE_RESET;
		back_q = BACK_RESET;
		bold_q = 1'b0;
		inverse_q = 1'b0;
		conceal_q = 1'b0;
		burst_left = 0;
		errors = 0;
		chars_sent = 0;
		results_seen = 0;
		writes_seen = 0;
		markers_seen = 0;
		reg_writes = 0;
		rx_tick = 0;
		rx_mode = RX_OPEN;
		ending_seen = "none";
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_attributes();
		test_controls();
		test_random_text();
		test_page_end();
		drain_results();
		repeat (10) @(negedge clk);

		$display("Sent %0d characters and %0d register writes; checked %0d results", chars_sent,
			reg_writes, results_seen);
		$display("(%0d cell writes, %0d continuation markers); page ended by %s.", writes_seen,
			markers_seen, ending_seen);
		if (errors == 0 && pending_cells.size() == 0) begin
			$display("** text_console_cell_writer: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending_cells.size());
			$display("** text_console_cell_writer: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pending_cells.size());
		$display("** text_console_cell_writer: FAILED **");
		$finish;
	end

endmodule
